/* hdl/ptrs_pkg.sv */
// Shared constants and control types for the periodic task release scheduler.
package ptrs_pkg;

  // Field widths of the request and response words
  localparam int unsigned IdxInW     = 8;
  localparam int unsigned TimeW      = 16;
  localparam int unsigned MaskW      = 8;

  // Default slot count of the task table
  localparam int unsigned NumTasksDef = 8;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic capture;   // latch the accepted request word
    logic create;    // perform the create on the latched request
    logic mask_clr;  // clear the due mask before a slot walk
    logic rd_en;     // read one slot from the table
    logic wb_en;     // update the slot read in the previous cycle
    logic load_out;  // move the result into the response register
  } cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic is_create; // latched request is a create
  } stat_t;

endpackage

/* hdl/ptrs_if.sv */
// Valid/ready channel interfaces for request and response words.
interface ptrs_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [ptrs_pkg::IdxInW-1:0]   task_index;
  logic [ptrs_pkg::TimeW-1:0]    period;
  logic [ptrs_pkg::TimeW-1:0]    first_delay;
  logic                          has_handler;

  modport source (
    output valid, req_type, task_index, period, first_delay, has_handler,
    input  ready
  );
  modport sink (
    input  valid, req_type, task_index, period, first_delay, has_handler,
    output ready
  );
endinterface

interface ptrs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          is_create_ack;
  logic                          status;
  logic [ptrs_pkg::MaskW-1:0]    due_mask;

  modport source (
    output valid, is_create_ack, status, due_mask,
    input  ready
  );
  modport sink (
    input  valid, is_create_ack, status, due_mask,
    output ready
  );
endinterface

/* hdl/periodic_task_release_scheduler.sv */
// Top level of the periodic task release scheduler.
//
// Request channel (req_if): one word per item. req_type 1 creates or
// replaces task slot task_index with first_delay and period; it answers
// status 1 if the slot is out of range or has_handler is 0. req_type 0 is
// one scheduler tick.
// Response channel (rsp_if): exactly one word per request. A tick answers
// due_mask with bit i set for each slot i below MaskW released on that tick.
// A create passes from accept through the dispatch and finish states to
// response valid. A tick walks the table one slot per cycle through the read
// port of the slot memories; that walk sets the rate.
// Requests are handled one at a time; the next request is accepted as soon
// as the previous result sits in the response register.
// Reset clears all valid marks, so no slot fires until it is created.
// When the receiver stalls, the response word holds; a finished result
// waits in the sequencer until the response register frees up.
module periodic_task_release_scheduler #(
  parameter int unsigned NumTasks = ptrs_pkg::NumTasksDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptrs_req_if.sink    req_if,
  ptrs_rsp_if.source  rsp_if
);

  localparam int unsigned IdxW = (NumTasks > 1) ? $clog2(NumTasks) : 1;

  ptrs_pkg::cmd_t   cmd;
  ptrs_pkg::stat_t  stat;
  logic [IdxW-1:0]  rd_addr;
  logic [IdxW-1:0]  wb_addr;

  // sequencer
  ptrs_ctrl #(
    .NumTasks (NumTasks),
    .IdxW     (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_if.valid),
    .in_ready_o  (req_if.ready),
    .out_valid_o (rsp_if.valid),
    .out_ready_i (rsp_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .wb_addr_o   (wb_addr)
  );

  // datapath
  ptrs_dp #(
    .NumTasks (NumTasks),
    .IdxW     (IdxW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .rd_addr_i       (rd_addr),
    .wb_addr_i       (wb_addr),
    .stat_o          (stat),
    .req_type_i      (req_if.req_type),
    .task_index_i    (req_if.task_index),
    .period_i        (req_if.period),
    .first_delay_i   (req_if.first_delay),
    .has_handler_i   (req_if.has_handler),
    .is_create_ack_o (rsp_if.is_create_ack),
    .status_o        (rsp_if.status),
    .due_mask_o      (rsp_if.due_mask)
  );

endmodule

/* hdl/ptrs_dp.sv */
// Datapath: request latch, slot table memories, due mask and response register.
module ptrs_dp #(
  parameter int unsigned NumTasks = ptrs_pkg::NumTasksDef,
  parameter int unsigned IdxW     = (NumTasks > 1) ? $clog2(NumTasks) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ptrs_pkg::cmd_t               cmd_i,
  input  logic [IdxW-1:0]              rd_addr_i,
  input  logic [IdxW-1:0]              wb_addr_i,
  output ptrs_pkg::stat_t              stat_o,
  // request payload
  input  logic                         req_type_i,
  input  logic [ptrs_pkg::IdxInW-1:0]  task_index_i,
  input  logic [ptrs_pkg::TimeW-1:0]   period_i,
  input  logic [ptrs_pkg::TimeW-1:0]   first_delay_i,
  input  logic                         has_handler_i,
  // response payload
  output logic                         is_create_ack_o,
  output logic                         status_o,
  output logic [ptrs_pkg::MaskW-1:0]   due_mask_o
);

  // latched request word
  logic                         req_type_q;
  logic [ptrs_pkg::IdxInW-1:0]  task_index_q;
  logic [ptrs_pkg::TimeW-1:0]   period_q;
  logic [ptrs_pkg::TimeW-1:0]   first_delay_q;
  logic                         has_handler_q;

  // slot table
  logic [NumTasks-1:0]          valid_q;
  logic [ptrs_pkg::TimeW-1:0]   cd_mem  [NumTasks];
  logic [ptrs_pkg::TimeW-1:0]   per_mem [NumTasks];
  logic [ptrs_pkg::TimeW-1:0]   cd_rd_q;
  logic [ptrs_pkg::TimeW-1:0]   per_rd_q;

  // walk and result state
  logic                         create_ok;
  logic                         err_q;
  logic                         slot_live;
  logic                         slot_due;
  logic [ptrs_pkg::TimeW-1:0]   cd_next;
  logic [ptrs_pkg::MaskW-1:0]   mask_d, mask_q;
  logic [IdxW-1:0]              create_addr;

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q    <= req_type_i;
      task_index_q  <= task_index_i;
      period_q      <= period_i;
      first_delay_q <= first_delay_i;
      has_handler_q <= has_handler_i;
    end
  end

  assign stat_o.is_create = req_type_q;

  // create checks: slot in range and handler present
  assign create_ok   = has_handler_q &&
                       (task_index_q < ptrs_pkg::IdxInW'(NumTasks));
  assign create_addr = task_index_q[IdxW-1:0];

  // slot update during the walk
  assign slot_live = valid_q[wb_addr_i];
  assign slot_due  = slot_live && (cd_rd_q == '0);
  assign cd_next   = (cd_rd_q == '0) ? (per_rd_q - ptrs_pkg::TimeW'(1))
                                     : (cd_rd_q - ptrs_pkg::TimeW'(1));

  // valid marks, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.create && create_ok) begin
      valid_q[create_addr] <= 1'b1;
    end
  end

  // countdown memory: create write or walk write-back
  always_ff @(posedge clk_i) begin
    if (cmd_i.create && create_ok) begin
      cd_mem[create_addr] <= first_delay_q;
    end else if (cmd_i.wb_en && slot_live) begin
      cd_mem[wb_addr_i] <= cd_next;
    end
  end

  // period memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.create && create_ok) begin
      per_mem[create_addr] <= period_q;
    end
  end

  // registered read port of both memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      cd_rd_q  <= cd_mem[rd_addr_i];
      per_rd_q <= per_mem[rd_addr_i];
    end
  end

  // due mask accumulation; slots past the mask width are not reported
  always_comb begin
    mask_d = mask_q;
    if (cmd_i.mask_clr) begin
      mask_d = '0;
    end else if (cmd_i.wb_en && slot_due) begin
      for (int b = 0; b < ptrs_pkg::MaskW; b++) begin
        if (b < NumTasks) begin
          if (wb_addr_i == IdxW'(b)) begin
            mask_d[b] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    if (cmd_i.create) begin
      err_q <= ~create_ok;
    end
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      is_create_ack_o <= req_type_q;
      status_o        <= req_type_q & err_q;
      due_mask_o      <= req_type_q ? '0 : mask_q;
    end
  end

endmodule

/* hdl/ptrs_ctrl.sv */
// Sequencer: handshakes, create dispatch and the one-slot-per-cycle table walk.
module ptrs_ctrl #(
  parameter int unsigned NumTasks = ptrs_pkg::NumTasksDef,
  parameter int unsigned IdxW     = (NumTasks > 1) ? $clog2(NumTasks) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ptrs_pkg::stat_t  stat_i,
  output ptrs_pkg::cmd_t   cmd_o,
  output logic [IdxW-1:0]  rd_addr_o,
  output logic [IdxW-1:0]  wb_addr_o
);

  localparam int unsigned CntW = $clog2(NumTasks + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK,
    S_FINISH
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  rd_cnt_q;
  logic             wb_vld_q;
  logic [IdxW-1:0]  wb_addr_q;
  logic             out_valid_q;
  logic             rd_more;
  logic             out_free;

  assign rd_more   = (rd_cnt_q < CntW'(NumTasks));
  assign out_free  = !out_valid_q || out_ready_i;
  assign rd_addr_o = rd_cnt_q[IdxW-1:0];
  assign wb_addr_o = wb_addr_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.create   = (state_q == S_DISPATCH) && stat_i.is_create;
    cmd_o.mask_clr = (state_q == S_DISPATCH) && !stat_i.is_create;
    cmd_o.rd_en    = (state_q == S_WALK) && rd_more;
    cmd_o.wb_en    = (state_q == S_WALK) && wb_vld_q;
    cmd_o.load_out = (state_q == S_FINISH) && out_free;
  end

  // state, walk counters and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_cnt_q    <= '0;
      wb_vld_q    <= 1'b0;
      wb_addr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // response valid: set on load, cleared when the word is taken
      if ((state_q == S_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          rd_cnt_q <= '0;
          wb_vld_q <= 1'b0;
          state_q  <= stat_i.is_create ? S_FINISH : S_WALK;
        end
        S_WALK: begin
          wb_vld_q  <= rd_more;
          wb_addr_q <= rd_cnt_q[IdxW-1:0];
          if (rd_more) begin
            rd_cnt_q <= rd_cnt_q + CntW'(1);
          end else if (!wb_vld_q) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
